FILE: sv/ism_pkg.sv
// Package: shared types, opcodes and constants of the integer stack machine.
package ism_pkg;

   localparam int STACK_DEPTH_DEF = 64;
   localparam int LOCAL_COUNT_DEF = 256;
   localparam int DATA_W = 32;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [3:0] {
      OP_PUSH = 4'd0,
      OP_DUP  = 4'd1,
      OP_STORE = 4'd2,
      OP_LOAD = 4'd3,
      OP_ADD  = 4'd4,
      OP_SUB  = 4'd5,
      OP_MUL  = 4'd6,
      OP_DIV  = 4'd7,
      OP_REM  = 4'd8,
      OP_NEG  = 4'd9,
      OP_AND  = 4'd10,
      OP_OR   = 4'd11,
      OP_XOR  = 4'd12,
      OP_NOP  = 4'd13
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2,
      ST_DIVZ  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OPS_NONE = 2'd0,
      OPS_ONE  = 2'd1,
      OPS_TWO  = 2'd2
   } ops_type;

   typedef struct packed {
      op_type     op;
      ops_type    need;
      logic       grows;
      logic       [DATA_W-1:0] value;
      logic       [7:0] index;
   } instr_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EXEC,
      S_DIV,
      S_WRITE,
      S_RESP
   } state_type;

endpackage

FILE: sv/integer_stack_machine.sv
// Top level: integer operand-stack machine with decoupled decode and execute.
// Each instruction passes through the execute sequencer's read, execute, write and
// response steps; div and rem add a step in the one-bit-per-cycle iterative divider.
// The sequencer starts the next instruction only after the previous response has been
// taken; the front-end queue can hold further requests meanwhile.
// Reset: synchronous; stack emptied at once, then a clearing pass zeroes all
// locals before instructions execute.
module integer_stack_machine #(
   parameter int STACK_DEPTH = ism_pkg::STACK_DEPTH_DEF,
   parameter int LOCAL_COUNT = ism_pkg::LOCAL_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // req_type[3:0], push_value[35:4], local_index[43:36]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata    // status[1:0], top_value[33:2], top_valid[34],
                                    // stack_depth[41:35], local_value[73:42]
);
   import ism_pkg::*;

   logic      q_valid, q_take;
   instr_type q_instr;

   ism_front u_front (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .q_valid(q_valid), .q_take(q_take), .q_instr(q_instr));

   ism_back #(.STACK_DEPTH(STACK_DEPTH), .LOCAL_COUNT(LOCAL_COUNT)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_take(q_take),
      .q_instr(q_instr), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata));
endmodule

FILE: sv/ism_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ism_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

FILE: sv/ism_front.sv
// Front end: accepts requests, decodes them and queues them for execution.
module ism_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [47:0]          req_tdata,
   output logic                 q_valid,
   input  logic                 q_take,
   output ism_pkg::instr_type   q_instr
);
   import ism_pkg::*;

   instr_type       dec;
   instr_type       q_ff [QUEUE_DEPTH];
   logic            wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0]      cnt_ff, cnt_in;
   logic            push, pop;

   always_comb begin
      dec.value = req_tdata[35:4];
      dec.index = req_tdata[43:36];
      dec.grows = 1'b0;
      dec.need  = OPS_NONE;
      dec.op    = OP_NOP;
      case (req_tdata[3:0])
         OP_PUSH:  begin dec.op = OP_PUSH; dec.grows = 1'b1; end
         OP_DUP:   begin dec.op = OP_DUP; dec.grows = 1'b1; dec.need = OPS_ONE; end
         OP_STORE: begin dec.op = OP_STORE; dec.need = OPS_ONE; end
         OP_LOAD:  begin dec.op = OP_LOAD; dec.grows = 1'b1; end
         OP_NEG:   begin dec.op = OP_NEG; dec.need = OPS_ONE; end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM, OP_AND, OP_OR, OP_XOR: begin
            dec.op = op_type'(req_tdata[3:0]);
            dec.need = OPS_TWO;
         end
         default: dec.op = OP_NOP;
      endcase
   end

   assign req_tready = (cnt_ff != 2'(QUEUE_DEPTH));
   assign push = req_tvalid && req_tready;
   assign pop = q_take && q_valid;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_instr = q_ff[rptr_ff];
   assign wptr_in = push ? ~wptr_ff : wptr_ff;
   assign rptr_in = pop ? ~rptr_ff : rptr_ff;
   assign cnt_in = cnt_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wptr_ff] <= dec;
      end
   end

`ifndef SYNTHESIS
   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(QUEUE_DEPTH)) else $error("queue count overflow");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> !pop) else $error("pop from empty queue");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'(QUEUE_DEPTH) |-> !push) else $error("push into full queue");
`endif
endmodule

FILE: sv/ism_div.sv
// Iterative signed divider: one quotient bit per cycle, truncating toward zero.
module ism_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient,
   output logic [31:0] remainder
);
   logic [31:0] q_ff, q_in, d_ff, d_in;
   logic [32:0] r_ff, r_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, qneg_ff, qneg_in, rneg_ff, rneg_in;
   logic [32:0] trial;
   logic [32:0] shifted;

   assign shifted = {r_ff[31:0], q_ff[31]};
   assign trial = shifted - {1'b0, d_ff};

   always_comb begin
      q_in = q_ff;
      d_in = d_ff;
      r_in = r_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      qneg_in = qneg_ff;
      rneg_in = rneg_ff;
      if (start) begin
         q_in = dividend[31] ? 32'(-dividend) : dividend;
         d_in = divisor[31] ? 32'(-divisor) : divisor;
         r_in = '0;
         cnt_in = 6'd32;
         busy_in = 1'b1;
         qneg_in = dividend[31] ^ divisor[31];
         rneg_in = dividend[31];
      end else if (busy_ff) begin
         if (cnt_ff != 6'd0) begin
            if (!trial[32]) begin
               r_in = trial;
               q_in = {q_ff[30:0], 1'b1};
            end else begin
               r_in = shifted;
               q_in = {q_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      d_ff <= d_in;
      r_ff <= r_in;
      qneg_ff <= qneg_in;
      rneg_ff <= rneg_in;
   end

   assign done = busy_ff && (cnt_ff == 6'd0);
   assign quotient = qneg_ff ? 32'(-q_ff) : q_ff;
   assign remainder = rneg_ff ? 32'(-r_ff[31:0]) : r_ff[31:0];
endmodule

FILE: sv/ism_back.sv
// Back end: executes queued instructions on stack and local memories.
module ism_back #(
   parameter int STACK_DEPTH = ism_pkg::STACK_DEPTH_DEF,
   parameter int LOCAL_COUNT = ism_pkg::LOCAL_COUNT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_take,
   input  ism_pkg::instr_type q_instr,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [79:0]        rsp_tdata
);
   import ism_pkg::*;

   localparam int SA_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int LA_W = (LOCAL_COUNT > 1) ? $clog2(LOCAL_COUNT) : 1;
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int LDEPTH = 1 << LA_W;

   state_type         state_ff, state_in;
   instr_type         ins_ff, ins_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [31:0]       a_ff, a_in, b_ff, b_in, res_ff, res_in, top_ff, top_in;
   logic [1:0]        st_ff, st_in;
   logic              clr_ff;
   logic [LA_W-1:0]   clr_addr_ff;
   logic [79:0]       out_ff, out_in;
   logic              outv_ff, outv_in;

   logic              s_we, l_we;
   logic [SA_W-1:0]   s_waddr, s_raddr0, s_raddr1;
   logic [31:0]       s_wdata, s_rdata0, s_rdata1;
   logic [LA_W-1:0]   l_addr, l_waddr;
   logic [31:0]       l_wdata, l_rdata;
   logic              div_start, div_done;
   logic [31:0]       div_q, div_r;
   logic [31:0]       mul_p;
   logic [CNT_W-1:0]  n;
   logic [31:0]       wb_value;
   logic              wb_stack;
   logic [CNT_W-1:0]  wb_cnt;
   logic [LA_W-1:0]   slot_map [256];

   ism_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack0 (
      .clock(clock), .wr_en(s_we), .wr_addr(s_waddr), .wr_data(s_wdata),
      .rd_addr(s_raddr0), .rd_data(s_rdata0));
   ism_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack1 (
      .clock(clock), .wr_en(s_we), .wr_addr(s_waddr), .wr_data(s_wdata),
      .rd_addr(s_raddr1), .rd_data(s_rdata1));
   ism_ram #(.WIDTH(32), .DEPTH(LDEPTH)) u_locals (
      .clock(clock), .wr_en(l_we), .wr_addr(l_waddr), .wr_data(l_wdata),
      .rd_addr(l_addr), .rd_data(l_rdata));
   ism_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(s_rdata1),
      .divisor(s_rdata0), .done(div_done), .quotient(div_q), .remainder(div_r));

   // Local slot wraps modulo LOCAL_COUNT: constant lookup table.
   for (genvar gi = 0; gi < 256; gi++) begin : g_slot
      assign slot_map[gi] = LA_W'(gi % LOCAL_COUNT);
   end

   assign n = cnt_ff;
   assign mul_p = b_ff * a_ff;
   assign l_addr = clr_ff ? clr_addr_ff : slot_map[ins_ff.index];
   assign s_raddr0 = SA_W'(n - CNT_W'(1));
   assign s_raddr1 = SA_W'(n - CNT_W'(2));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (q_valid && !clr_ff && !outv_ff) state_in = S_READ;
         S_READ:  state_in = S_EXEC;
         S_EXEC:  state_in = (st_in == ST_OK && (ins_ff.op == OP_DIV || ins_ff.op == OP_REM))
                             ? S_DIV : S_WRITE;
         S_DIV:   if (div_done) state_in = S_WRITE;
         S_WRITE: state_in = S_RESP;
         S_RESP:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      ins_in = ins_ff;
      a_in = a_ff;
      b_in = b_ff;
      res_in = res_ff;
      st_in = st_ff;
      cnt_in = cnt_ff;
      top_in = top_ff;
      q_take = 1'b0;
      div_start = 1'b0;
      s_we = 1'b0;
      s_waddr = '0;
      s_wdata = '0;
      l_we = clr_ff;
      l_waddr = clr_addr_ff;
      l_wdata = '0;
      wb_stack = 1'b0;
      wb_value = res_ff;
      wb_cnt = cnt_ff;
      out_in = out_ff;
      outv_in = outv_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (q_valid && !clr_ff && !outv_ff) begin
               q_take = 1'b1;
               ins_in = q_instr;
            end
         end
         S_READ: ;
         S_EXEC: begin
            a_in = s_rdata0;
            b_in = s_rdata1;
            st_in = ST_OK;
            if ((ins_ff.need == OPS_ONE && n < CNT_W'(1)) ||
                (ins_ff.need == OPS_TWO && n < CNT_W'(2))) begin
               st_in = ST_UNDER;
            end else if (ins_ff.grows && n >= CNT_W'(STACK_DEPTH)) begin
               st_in = ST_OVER;
            end else if ((ins_ff.op == OP_DIV || ins_ff.op == OP_REM) &&
                         s_rdata0 == 32'd0) begin
               st_in = ST_DIVZ;
            end
            div_start = (st_in == ST_OK) && (ins_ff.op == OP_DIV || ins_ff.op == OP_REM);
         end
         S_DIV: begin
            if (div_done) begin
               res_in = (ins_ff.op == OP_DIV) ? div_q : div_r;
            end
         end
         S_WRITE: begin
            if (st_ff == ST_OK) begin
               case (ins_ff.op)
                  OP_PUSH:  begin wb_stack = 1'b1; wb_value = ins_ff.value;
                                  wb_cnt = n + CNT_W'(1); end
                  OP_DUP:   begin wb_stack = 1'b1; wb_value = a_ff;
                                  wb_cnt = n + CNT_W'(1); end
                  OP_LOAD:  begin wb_stack = 1'b1; wb_value = l_rdata;
                                  wb_cnt = n + CNT_W'(1); end
                  OP_STORE: begin
                     l_we = 1'b1; l_waddr = l_addr; l_wdata = a_ff;
                     wb_cnt = n - CNT_W'(1);
                  end
                  OP_NEG:   begin wb_stack = 1'b1; wb_value = 32'(-a_ff); wb_cnt = n; end
                  OP_ADD:   begin wb_stack = 1'b1; wb_value = b_ff + a_ff;
                                  wb_cnt = n - CNT_W'(1); end
                  OP_SUB:   begin wb_stack = 1'b1; wb_value = b_ff - a_ff;
                                  wb_cnt = n - CNT_W'(1); end
                  OP_MUL:   begin wb_stack = 1'b1; wb_value = mul_p;
                                  wb_cnt = n - CNT_W'(1); end
                  OP_DIV, OP_REM: begin wb_stack = 1'b1; wb_value = res_ff;
                                  wb_cnt = n - CNT_W'(1); end
                  OP_AND:   begin wb_stack = 1'b1; wb_value = b_ff & a_ff;
                                  wb_cnt = n - CNT_W'(1); end
                  OP_OR:    begin wb_stack = 1'b1; wb_value = b_ff | a_ff;
                                  wb_cnt = n - CNT_W'(1); end
                  OP_XOR:   begin wb_stack = 1'b1; wb_value = b_ff ^ a_ff;
                                  wb_cnt = n - CNT_W'(1); end
                  default:  wb_cnt = n;
               endcase
            end
            if (wb_stack) begin
               s_we = 1'b1;
               s_waddr = SA_W'(wb_cnt - CNT_W'(1));
               s_wdata = wb_value;
            end
            cnt_in = wb_cnt;
            // Top after the step: new value, old next entry, or unchanged.
            if (wb_stack) begin
               top_in = wb_value;
            end else if (wb_cnt == n) begin
               top_in = a_ff;
            end else begin
               top_in = b_ff;
            end
         end
         S_RESP: begin
            outv_in = 1'b1;
            // Local read data is one write behind after a store.
            out_in = {6'd0,
                      (st_ff == ST_OK && ins_ff.op == OP_STORE) ? a_ff : l_rdata,
                      7'(n), (n != '0), (n != '0) ? top_ff : 32'd0, st_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         outv_ff <= 1'b0;
         clr_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         outv_ff <= outv_in;
         if (clr_ff) begin
            clr_addr_ff <= clr_addr_ff + LA_W'(1);
            if (clr_addr_ff == LA_W'(LDEPTH - 1)) begin
               clr_ff <= 1'b0;
            end
         end
      end
      ins_ff <= ins_in;
      a_ff <= a_in;
      b_ff <= b_in;
      res_ff <= res_in;
      st_ff <= st_in;
      top_ff <= top_in;
      out_ff <= out_in;
   end

   assign rsp_tvalid = outv_ff;
   assign rsp_tdata = out_ff;

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(STACK_DEPTH)) else $error("stack count out of range");
   a_fault_keeps: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WRITE && st_ff != ST_OK |-> !s_we && !l_we && cnt_in == cnt_ff)
      else $error("faulting instruction changed state");
   a_no_take_clear: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !q_take) else $error("instruction taken during clear");
   a_div_zero: assert property (@(posedge clock) disable iff (reset)
      div_start |-> a_in != 32'd0) else $error("divide started with zero divisor");
`endif
endmodule

FILE: bench/integer_stack_machine_tb.sv
// Testbench: random and directed instruction streams checked against a stack-machine predictor.
module integer_stack_machine_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ism_pkg::*;

   localparam int DEPTH = STACK_DEPTH_DEF;
   localparam int LOCALS = LOCAL_COUNT_DEF;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic [31:0] local_value;
      logic [6:0]  stack_depth;
      logic        top_valid;
      logic [31:0] top_value;
      logic [1:0]  status;
   } outcome_type;

   class stack_scoreboard;
      logic [31:0] stack[DEPTH];
      logic [31:0] locals[LOCALS];
      int count;
      outcome_type pending[$];
      int errors;

      function new();
         foreach (locals[i]) locals[i] = '0;
         foreach (stack[i]) stack[i] = '0;
         count = 0;
         errors = 0;
      endfunction

      function void note_request(logic [3:0] op, logic [31:0] pv, logic [7:0] idx);
         logic [1:0] st;
         logic [31:0] a, b, r;
         int slot;
         outcome_type o;
         st = ST_OK;
         slot = idx % LOCALS;
         case (op)
            OP_PUSH: begin
               if (count >= DEPTH) st = ST_OVER;
               else begin stack[count] = pv; count++; end
            end
            OP_DUP: begin
               if (count < 1) st = ST_UNDER;
               else if (count >= DEPTH) st = ST_OVER;
               else begin stack[count] = stack[count-1]; count++; end
            end
            OP_STORE: begin
               if (count < 1) st = ST_UNDER;
               else begin locals[slot] = stack[count-1]; count--; end
            end
            OP_LOAD: begin
               if (count >= DEPTH) st = ST_OVER;
               else begin stack[count] = locals[slot]; count++; end
            end
            OP_NEG: begin
               if (count < 1) st = ST_UNDER;
               else stack[count-1] = -stack[count-1];
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM, OP_AND, OP_OR, OP_XOR: begin
               if (count < 2) st = ST_UNDER;
               else if ((op == OP_DIV || op == OP_REM) && stack[count-1] == 0) st = ST_DIVZ;
               else begin
                  b = stack[count-2];
                  a = stack[count-1];
                  case (op)
                     OP_ADD: r = b + a;
                     OP_SUB: r = b - a;
                     OP_MUL: r = b * a;
                     OP_DIV: r = (b == 32'h8000_0000 && a == '1) ? b :
                                 32'($signed(b) / $signed(a));
                     OP_REM: r = (b == 32'h8000_0000 && a == '1) ? '0 :
                                 32'($signed(b) % $signed(a));
                     OP_AND: r = b & a;
                     OP_OR:  r = b | a;
                     default: r = b ^ a;
                  endcase
                  stack[count-2] = r;
                  count--;
               end
            end
            default: ;
         endcase
         o.status = st;
         o.top_valid = count > 0;
         o.top_value = count > 0 ? stack[count-1] : '0;
         o.stack_depth = count[6:0];
         o.local_value = locals[slot];
         pending.push_back(o);
      endfunction

      function void check_response(logic [79:0] data);
         outcome_type got, want;
         got = data[73:0];
         if (pending.size() == 0) begin
            $error("response with nothing pending");
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status) begin
            $error("status exp %0d got %0d", want.status, got.status); errors++;
         end
         if (got.top_value !== want.top_value) begin
            $error("top_value exp %h got %h", want.top_value, got.top_value); errors++;
         end
         if (got.top_valid !== want.top_valid) begin
            $error("top_valid exp %0d got %0d", want.top_valid, got.top_valid); errors++;
         end
         if (got.stack_depth !== want.stack_depth) begin
            $error("stack_depth exp %0d got %0d", want.stack_depth, got.stack_depth); errors++;
         end
         if (got.local_value !== want.local_value) begin
            $error("local_value exp %h got %h", want.local_value, got.local_value); errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [79:0] rsp_tdata;

   integer_stack_machine dut (.*);

   always #5 clock = ~clock;

   stack_scoreboard sb = new();
   int send_idle = 0;
   int recv_stall = 0;
   bit hold_off = 0;
   int quiet = 0;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
      if (hold_off) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_stall);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic send_request(logic [3:0] op, logic [31:0] pv, logic [7:0] idx);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata <= {4'b0, idx, pv, op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, pv, idx);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() > 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '1;
         3: return 32'($urandom_range(4)) - 2;
         default: return $urandom();
      endcase
   endfunction

   task automatic random_request();
      logic [3:0] op;
      int r;
      r = $urandom_range(99);
      if (r < 3) op = 4'($urandom_range(13, 15));
      else if (sb.count < 3 && r < 60) op = OP_PUSH;
      else if (sb.count > 50 && r < 60) op = OP_STORE;
      else op = 4'($urandom_range(0, 12));
      send_request(op, pick_value(), 8'($urandom()));
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // directed
      send_request(OP_ADD, 0, 0);
      send_request(OP_DUP, 0, 0);
      send_request(OP_STORE, 0, 0);
      send_request(OP_NEG, 0, 0);
      send_request(OP_LOAD, 0, 8'hff);
      send_request(OP_PUSH, 32'h8000_0000, 0);
      send_request(OP_PUSH, 32'hffff_ffff, 0);
      send_request(OP_DIV, 0, 0);
      send_request(OP_PUSH, 32'hffff_ffff, 0);
      send_request(OP_REM, 0, 0);
      send_request(OP_PUSH, 32'h7fff_ffff, 0);
      send_request(OP_DIV, 0, 0);
      send_request(OP_PUSH, 32'd7, 0);
      send_request(OP_PUSH, -32'sd2, 0);
      send_request(OP_REM, 0, 0);
      send_request(OP_DUP, 0, 0);
      send_request(OP_MUL, 0, 0);
      send_request(OP_NEG, 0, 0);
      send_request(OP_STORE, 0, 8'hff);
      send_request(OP_LOAD, 0, 8'hff);
      send_request(OP_SUB, 0, 0);
      send_request(OP_AND, 0, 0);
      send_request(OP_OR, 0, 0);
      send_request(OP_XOR, 0, 0);
      send_request(4'hf, 0, 0);
      // overflow: push past the stack depth, starting while the receiver holds off
      drain();
      hold_off = 1;
      fork
         begin repeat (400) @(posedge clock); hold_off = 0; end
         repeat (DEPTH + 2) send_request(OP_PUSH, $urandom(), 0);
      join
      send_request(OP_DUP, 0, 0);
      send_request(OP_LOAD, 0, 3);
      drain();
      repeat (DEPTH) send_request(OP_STORE, 0, 8'($urandom()));
      drain();
      for (int phase = 0; phase < 4; phase++) begin
         send_idle = (phase == 1 || phase == 3) ? (phase == 1 ? 78 : 10) : 0;
         recv_stall = (phase == 2) ? 78 : (phase == 3 ? 10 : 0);
         repeat (390) random_request();
      end
      drain();
      repeat (60) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end
endmodule
